@@ sv/rfc_pkg.sv @@
// Shared types and constants for the response frame checker.
// Holds the channel payload structs, configuration struct and error codes.
// No dependencies.
package rfc_pkg;

    // frame layout constants
    localparam logic [7:0]  HEADER_FIRST   = 8'hCC;
    localparam logic [7:0]  FOOTER_CR      = 8'h0D;
    localparam logic [7:0]  FOOTER_LF      = 8'h0A;
    localparam logic [7:0]  STATUS_OK      = 8'h00;
    localparam logic [7:0]  STATUS_INVALID = 8'h15;
    localparam logic [7:0]  STATUS_UNSUPP  = 8'hFF;
    localparam logic [23:0] COUNT_MAX      = 24'hFFFFFF;
    localparam logic [23:0] FRAME_OVERHEAD = 24'd9;

    // byte positions inside a frame
    localparam logic [23:0] POS_HEADER0   = 24'd0;
    localparam logic [23:0] POS_HEADER1   = 24'd1;
    localparam logic [23:0] POS_LEN0      = 24'd2;
    localparam logic [23:0] POS_LEN1      = 24'd3;
    localparam logic [23:0] POS_LEN2      = 24'd4;
    localparam logic [23:0] POS_TYPE      = 24'd5;
    localparam logic [23:0] POS_PAYLOAD   = 24'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_TYPE   = 2'd0;
    localparam logic [1:0] CFG_RESPONSE_HEADER = 2'd1;
    localparam logic [1:0] CFG_STATUS_MODE     = 2'd2;

    localparam logic [7:0] RESPONSE_HEADER_RST = 8'h81;

    typedef enum logic [3:0] {
        ERR_OK             = 4'd0,
        ERR_SHORT          = 4'd1,
        ERR_HEADER         = 4'd2,
        ERR_LENGTH         = 4'd3,
        ERR_TYPE           = 4'd4,
        ERR_FOOTER         = 4'd5,
        ERR_CHECKSUM       = 4'd6,
        ERR_STATUS_LEN     = 4'd7,
        ERR_INVALID        = 4'd8,
        ERR_UNSUPPORTED    = 4'd9,
        ERR_UNKNOWN_STATUS = 4'd10
    } err_code_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } in_payload_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        payload_flag;
        logic        frame_done;
        err_code_t   error_code;
        logic [7:0]  frame_type;
        logic [23:0] payload_length;
    } out_payload_t;

    typedef struct packed {
        logic [7:0] expected_type;
        logic [7:0] response_header;
        logic       status_mode;
    } cfg_t;

endpackage

@@ sv/rfc_stream_if.sv @@
// Valid/ready stream channel used for both byte input and result output.
// The payload type is a parameter; no package dependency.
interface rfc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

@@ sv/rfc_frame_tracker.sv @@
// Per-frame state (count, checksum window, header fields) and the verdict.
// Produces one result per stepped byte, combinationally from current state.
// Depends on rfc_pkg.
module rfc_frame_tracker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  rfc_pkg::in_payload_t  item,
    input  rfc_pkg::cfg_t         cfg,
    output rfc_pkg::out_payload_t result
);

    logic [23:0] count_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  recent_reg [0:2];
    logic [23:0] dlen_reg;
    logic        hdr_bad_reg;
    logic [7:0]  type_reg;
    logic [7:0]  first_reg;

    logic [23:0] count_next;
    logic [7:0]  sum_next;
    logic [7:0]  recent_next [0:2];
    logic [23:0] dlen_next;
    logic        hdr_bad_next;
    logic [7:0]  type_next;
    logic [7:0]  first_next;

    logic [24:0]          pos_plus3;
    logic                 flag;
    rfc_pkg::err_code_t   verdict;
    logic [23:0]          pay_len;

    // capture header fields by position
    always_comb
    begin
        hdr_bad_next = hdr_bad_reg;
        dlen_next    = dlen_reg;
        type_next    = type_reg;
        first_next   = first_reg;
        case (count_reg)
            rfc_pkg::POS_HEADER0: hdr_bad_next = (item.rx_byte != rfc_pkg::HEADER_FIRST);
            rfc_pkg::POS_HEADER1: hdr_bad_next = hdr_bad_reg |
                                                 (item.rx_byte != cfg.response_header);
            rfc_pkg::POS_LEN0:    dlen_next[7:0]   = item.rx_byte;
            rfc_pkg::POS_LEN1:    dlen_next[15:8]  = item.rx_byte;
            rfc_pkg::POS_LEN2:    dlen_next[23:16] = item.rx_byte;
            rfc_pkg::POS_TYPE:    type_next  = item.rx_byte;
            rfc_pkg::POS_PAYLOAD: first_next = item.rx_byte;
            default: ;
        endcase
    end

    // checksum window and saturating count
    always_comb
    begin
        sum_next       = (count_reg >= rfc_pkg::POS_LEN1) ? sum_reg + recent_reg[2] : sum_reg;
        recent_next[0] = item.rx_byte;
        recent_next[1] = recent_reg[0];
        recent_next[2] = recent_reg[1];
        count_next     = (count_reg == rfc_pkg::COUNT_MAX) ? count_reg : count_reg + 24'd1;
    end

    // payload flag from the length already seen
    assign pos_plus3 = {1'b0, count_reg} + 25'd3;
    assign flag      = (count_reg >= rfc_pkg::POS_PAYLOAD) && (pos_plus3 < {1'b0, dlen_next});

    // first failed check in fixed order
    always_comb
    begin
        if (count_next < rfc_pkg::FRAME_OVERHEAD)
            verdict = rfc_pkg::ERR_SHORT;
        else if (hdr_bad_next)
            verdict = rfc_pkg::ERR_HEADER;
        else if (dlen_next != count_next)
            verdict = rfc_pkg::ERR_LENGTH;
        else if (cfg.expected_type != 8'd0 && type_next != cfg.expected_type)
            verdict = rfc_pkg::ERR_TYPE;
        else if (recent_next[1] != rfc_pkg::FOOTER_CR || recent_next[0] != rfc_pkg::FOOTER_LF)
            verdict = rfc_pkg::ERR_FOOTER;
        else if (sum_next != recent_next[2])
            verdict = rfc_pkg::ERR_CHECKSUM;
        else if (!cfg.status_mode)
            verdict = rfc_pkg::ERR_OK;
        else if (count_next != rfc_pkg::FRAME_OVERHEAD + 24'd1)
            verdict = rfc_pkg::ERR_STATUS_LEN;
        else if (first_next == rfc_pkg::STATUS_OK)
            verdict = rfc_pkg::ERR_OK;
        else if (first_next == rfc_pkg::STATUS_INVALID)
            verdict = rfc_pkg::ERR_INVALID;
        else if (first_next == rfc_pkg::STATUS_UNSUPP)
            verdict = rfc_pkg::ERR_UNSUPPORTED;
        else
            verdict = rfc_pkg::ERR_UNKNOWN_STATUS;
    end

    assign pay_len = (count_next >= rfc_pkg::FRAME_OVERHEAD) ?
                     count_next - rfc_pkg::FRAME_OVERHEAD : 24'd0;

    // result transaction, verdict fields only on the last byte
    always_comb
    begin
        result.data_byte    = item.rx_byte;
        result.payload_flag = flag;
        if (item.end_of_frame)
        begin
            result.frame_done     = 1'b1;
            result.error_code     = verdict;
            result.frame_type     = type_next;
            result.payload_length = pay_len;
        end
        else
        begin
            result.frame_done     = 1'b0;
            result.error_code     = rfc_pkg::ERR_OK;
            result.frame_type     = 8'd0;
            result.payload_length = 24'd0;
        end
    end

    // frame state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 24'd0;
            sum_reg       <= 8'd0;
            recent_reg[0] <= 8'd0;
            recent_reg[1] <= 8'd0;
            recent_reg[2] <= 8'd0;
            dlen_reg      <= 24'd0;
            hdr_bad_reg   <= 1'b0;
            type_reg      <= 8'd0;
            first_reg     <= 8'd0;
        end
        else if (step)
        begin
            if (item.end_of_frame)
            begin
                count_reg     <= 24'd0;
                sum_reg       <= 8'd0;
                recent_reg[0] <= 8'd0;
                recent_reg[1] <= 8'd0;
                recent_reg[2] <= 8'd0;
                dlen_reg      <= 24'd0;
                hdr_bad_reg   <= 1'b0;
                type_reg      <= 8'd0;
                first_reg     <= 8'd0;
            end
            else
            begin
                count_reg     <= count_next;
                sum_reg       <= sum_next;
                recent_reg[0] <= recent_next[0];
                recent_reg[1] <= recent_next[1];
                recent_reg[2] <= recent_next[2];
                dlen_reg      <= dlen_next;
                hdr_bad_reg   <= hdr_bad_next;
                type_reg      <= type_next;
                first_reg     <= first_next;
            end
        end
    end

endmodule

@@ sv/response_frame_checker_top.sv @@
// Top level of the response frame checker: input register, frame tracker,
// result register and configuration registers.
// Depends on rfc_pkg, rfc_stream_if and rfc_frame_tracker.

// The checker takes one received byte per transaction on rx and returns one
// result transaction per byte on tx, in order: the byte itself, a payload flag
// and, on the byte marked end_of_frame, the verdict, frame type and payload
// length. It sustains one byte per clock while tx accepts every result. An
// accepted byte is held in the input register, the combinational tracker update
// loads its result into the result register, and the result is offered on tx
// from there. While a result waits on tx the input register can still take
// one more byte, after which rx stalls until tx is accepted.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect the next
// cycle and should be made between frames with the pipeline empty.
module response_frame_checker_top (
    input  logic                clk,
    input  logic                rst_n,
    rfc_stream_if.sink          rx,
    rfc_stream_if.source        tx,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    rfc_pkg::cfg_t         cfg_reg;
    logic                  s1_valid_reg;
    rfc_pkg::in_payload_t  s1_item_reg;
    logic                  out_valid_reg;
    rfc_pkg::out_payload_t out_data_reg;

    rfc_pkg::out_payload_t result;
    logic                  out_free;
    logic                  advance;
    logic                  load;

    // handshake control
    assign out_free = !out_valid_reg || tx.ready;
    assign advance  = s1_valid_reg && out_free;
    assign rx.ready = !s1_valid_reg || out_free;
    assign load     = rx.valid && rx.ready;

    assign tx.valid = out_valid_reg;
    assign tx.data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_type   <= 8'd0;
            cfg_reg.response_header <= rfc_pkg::RESPONSE_HEADER_RST;
            cfg_reg.status_mode     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfc_pkg::CFG_EXPECTED_TYPE:   cfg_reg.expected_type   <= cfg_data;
                rfc_pkg::CFG_RESPONSE_HEADER: cfg_reg.response_header <= cfg_data;
                rfc_pkg::CFG_STATUS_MODE:     cfg_reg.status_mode     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s1_item_reg <= rx.data;
    end

    rfc_frame_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (tx.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    // an accepted byte is held in the input register next cycle
    a_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> s1_valid_reg)
        else $error("accepted byte not held in input register");

    // an advancing byte always yields a result transaction
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced byte produced no result");

    // a short frame reports no payload length
    a_short_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_done &&
         out_data_reg.error_code == rfc_pkg::ERR_SHORT) |-> out_data_reg.payload_length == 24'd0)
        else $error("short frame with nonzero payload length");

endmodule

@@ tb/response_frame_checker_top_tb.sv @@
// Self-checking testbench for response_frame_checker_top: streams framed bytes
// through rx and checks every tx result against a byte-level frame tracker.
// Depends on rfc_pkg, rfc_stream_if and the checker RTL.
module response_frame_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAP_MAX       = 17;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_BYTES  = 1500;
    localparam int PHASE_BYTES   = 200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 100;
    localparam int VERDICT_COUNT = 11;

    // index past the register list, writes to it must be ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // ways a generated frame can be damaged
    typedef enum int {
        FL_NONE,
        FL_HEADER0,
        FL_HEADER1,
        FL_LENGTH,
        FL_TYPE,
        FL_FOOTER,
        FL_CHECKSUM,
        FL_TRUNCATED,
        FL_NOISE
    } frame_flaw_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    rfc_stream_if #(.payload_t(rfc_pkg::in_payload_t))  rx_ch ();
    rfc_stream_if #(.payload_t(rfc_pkg::out_payload_t)) tx_ch ();

    response_frame_checker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .tx        (tx_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // byte stream waiting to be offered, and results owed by the checker
    rfc_pkg::in_payload_t  pending_bytes[$];
    rfc_pkg::out_payload_t expected_results[$];

    // tracker copy of the configuration and per-frame state
    rfc_pkg::cfg_t model_cfg;
    logic [23:0]   trk_count;
    logic [7:0]    trk_sum;
    logic [7:0]    trk_recent [0:2];
    logic [23:0]   trk_declared;
    logic          trk_hdr_bad;
    logic [7:0]    trk_type;
    logic [7:0]    trk_first;

    // run control and bookkeeping
    bit hold_req;
    bit sink_hold;
    bit src_quiet;
    bit sink_quiet;
    int src_gap;
    int sink_stall;
    int cycle_count;
    int mismatch_count;
    int results_checked;
    int bytes_pushed;
    int frames_queued;
    int settings_used;
    int flagged_bytes;
    bit verdict_hits [0:15];

    always #2 clk = ~clk;

    // per-frame state goes back to zero after every final byte
    function automatic void clear_frame_state();
        trk_count    = '0;
        trk_sum      = '0;
        trk_recent   = '{8'h00, 8'h00, 8'h00};
        trk_declared = '0;
        trk_hdr_bad  = 1'b0;
        trk_type     = '0;
        trk_first    = '0;
    endfunction

    // first failed check on the final byte, in the fixed order
    function automatic rfc_pkg::err_code_t frame_verdict(input logic [23:0] n);
        if (n < rfc_pkg::FRAME_OVERHEAD)
            return rfc_pkg::ERR_SHORT;
        if (trk_hdr_bad)
            return rfc_pkg::ERR_HEADER;
        if (trk_declared != n)
            return rfc_pkg::ERR_LENGTH;
        if (model_cfg.expected_type != 8'h00 && trk_type != model_cfg.expected_type)
            return rfc_pkg::ERR_TYPE;
        if (trk_recent[1] != rfc_pkg::FOOTER_CR || trk_recent[0] != rfc_pkg::FOOTER_LF)
            return rfc_pkg::ERR_FOOTER;
        if (trk_sum != trk_recent[2])
            return rfc_pkg::ERR_CHECKSUM;
        if (!model_cfg.status_mode)
            return rfc_pkg::ERR_OK;
        if (n - rfc_pkg::FRAME_OVERHEAD != 24'd1)
            return rfc_pkg::ERR_STATUS_LEN;
        if (trk_first == rfc_pkg::STATUS_OK)
            return rfc_pkg::ERR_OK;
        if (trk_first == rfc_pkg::STATUS_INVALID)
            return rfc_pkg::ERR_INVALID;
        if (trk_first == rfc_pkg::STATUS_UNSUPP)
            return rfc_pkg::ERR_UNSUPPORTED;
        return rfc_pkg::ERR_UNKNOWN_STATUS;
    endfunction

    // advance the tracker by one byte and return the result it owes
    function automatic rfc_pkg::out_payload_t track_byte(input rfc_pkg::in_payload_t item);
        rfc_pkg::out_payload_t res;
        logic [23:0]           pos;
        logic [23:0]           n;
        logic [7:0]            b;
        b   = item.rx_byte;
        pos = trk_count;
        case (pos)
            rfc_pkg::POS_HEADER0: trk_hdr_bad = (b != rfc_pkg::HEADER_FIRST);
            rfc_pkg::POS_HEADER1: trk_hdr_bad = trk_hdr_bad |
                                                (b != model_cfg.response_header);
            rfc_pkg::POS_LEN0:    trk_declared[7:0]   = b;
            rfc_pkg::POS_LEN1:    trk_declared[15:8]  = b;
            rfc_pkg::POS_LEN2:    trk_declared[23:16] = b;
            rfc_pkg::POS_TYPE:    trk_type  = b;
            rfc_pkg::POS_PAYLOAD: trk_first = b;
            default: ;
        endcase
        res = '0;
        res.data_byte    = b;
        res.payload_flag = (pos >= rfc_pkg::POS_PAYLOAD) &&
                           (({1'b0, pos} + 25'd3) < {1'b0, trk_declared});
        // three-byte window: the sum only sees bytes that have left it
        if (pos >= rfc_pkg::POS_LEN1)
            trk_sum = trk_sum + trk_recent[2];
        trk_recent[2] = trk_recent[1];
        trk_recent[1] = trk_recent[0];
        trk_recent[0] = b;
        if (trk_count != rfc_pkg::COUNT_MAX)
            trk_count = trk_count + 24'd1;
        n = trk_count;
        if (item.end_of_frame)
        begin
            res.frame_done     = 1'b1;
            res.error_code     = frame_verdict(n);
            res.frame_type     = trk_type;
            res.payload_length = (n >= rfc_pkg::FRAME_OVERHEAD) ?
                                 n - rfc_pkg::FRAME_OVERHEAD : 24'd0;
            clear_frame_state();
        end
        return res;
    endfunction

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic void push_byte(input logic [7:0] b, input bit last);
        rfc_pkg::in_payload_t item;
        item.rx_byte      = b;
        item.end_of_frame = last;
        pending_bytes.push_back(item);
        bytes_pushed++;
    endfunction

    function automatic logic [7:0] pick_status();
        case ($urandom_range(0, 4))
            0: return rfc_pkg::STATUS_OK;
            1: return rfc_pkg::STATUS_INVALID;
            2: return rfc_pkg::STATUS_UNSUPP;
            default: return 8'($urandom);
        endcase
    endfunction

    // build one frame, optionally damaged; fill >= 0 sets every payload byte,
    // keep > 0 cuts the frame to that many bytes
    function automatic void queue_frame(input int pay_len, input frame_flaw_t flaw,
                                        input int fill, input int keep);
        logic [7:0]  fb[$];
        logic [23:0] decl;
        logic [7:0]  sum;
        logic [7:0]  ftype;
        logic [7:0]  cr;
        logic [7:0]  lf;
        logic [7:0]  pb;
        int          total;
        int          cut;
        total = pay_len + 9;
        cut   = keep;
        sum   = 8'h00;
        if (flaw == FL_NOISE)
        begin
            total = $urandom_range(1, 24);
            for (int i = 0; i < total; i++)
                fb.push_back(8'($urandom));
        end
        else
        begin
            decl = 24'(total);
            if (flaw == FL_LENGTH)
            begin
                if ($urandom_range(0, 2) == 0)
                    decl = 24'($urandom);
                else if ($urandom_range(0, 1) == 1)
                    decl = 24'(total + $urandom_range(1, 3));
                else
                    decl = 24'(total - $urandom_range(1, 3));
            end
            ftype = (model_cfg.expected_type != 8'h00) ? model_cfg.expected_type
                                                       : 8'($urandom);
            if (flaw == FL_TYPE)
                ftype = model_cfg.expected_type ^ 8'($urandom_range(1, 255));
            fb.push_back((flaw == FL_HEADER0)
                         ? rfc_pkg::HEADER_FIRST ^ 8'($urandom_range(1, 255))
                         : rfc_pkg::HEADER_FIRST);
            fb.push_back((flaw == FL_HEADER1)
                         ? model_cfg.response_header ^ 8'($urandom_range(1, 255))
                         : model_cfg.response_header);
            fb.push_back(decl[7:0]);
            fb.push_back(decl[15:8]);
            fb.push_back(decl[23:16]);
            fb.push_back(ftype);
            for (int i = 0; i < pay_len; i++)
            begin
                if (fill >= 0)
                    pb = 8'(fill);
                else if (model_cfg.status_mode && i == 0)
                    pb = pick_status();
                else
                    pb = 8'($urandom);
                fb.push_back(pb);
            end
            for (int i = 0; i < fb.size(); i++)
                sum = sum + fb[i];
            fb.push_back((flaw == FL_CHECKSUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
            cr = rfc_pkg::FOOTER_CR;
            lf = rfc_pkg::FOOTER_LF;
            if (flaw == FL_FOOTER)
            begin
                if ($urandom_range(0, 1) == 1)
                    cr = cr ^ 8'($urandom_range(1, 255));
                else
                    lf = lf ^ 8'($urandom_range(1, 255));
            end
            fb.push_back(cr);
            fb.push_back(lf);
            if (flaw == FL_TRUNCATED)
                cut = $urandom_range(1, total - 1);
        end
        if (cut > 0)
            while (fb.size() > cut)
                void'(fb.pop_back());
        for (int i = 0; i < fb.size(); i++)
            push_byte(fb[i], i == fb.size() - 1);
        frames_queued++;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch on %s at result %0d: got %0h, want %0h",
                     field, results_checked, got, want);
        mismatch_count++;
    endtask

    // register write; only called with the pipeline empty
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            rfc_pkg::CFG_EXPECTED_TYPE:   model_cfg.expected_type   = val;
            rfc_pkg::CFG_RESPONSE_HEADER: model_cfg.response_header = val;
            rfc_pkg::CFG_STATUS_MODE:     model_cfg.status_mode     = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] etype, input logic [7:0] rhdr,
                                  input logic smode);
        write_reg(rfc_pkg::CFG_EXPECTED_TYPE, etype);
        write_reg(rfc_pkg::CFG_RESPONSE_HEADER, rhdr);
        write_reg(rfc_pkg::CFG_STATUS_MODE, {7'd0, smode});
        settings_used++;
    endtask

    // wait until every queued byte has come back as a result
    task automatic wait_drained();
        while (results_checked != bytes_pushed)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // byte driver: offers queued bytes, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
            rx_ch.data  <= '0;
            src_gap     <= 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
                expected_results.push_back(track_byte(rx_ch.data));
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (src_gap != 0)
                begin
                    rx_ch.valid <= 1'b0;
                    src_gap     <= src_gap - 1;
                end
                else if (pending_bytes.size() != 0)
                begin
                    rx_ch.data  <= pending_bytes.pop_front();
                    rx_ch.valid <= 1'b1;
                    src_gap     <= draw_gap(src_quiet);
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor: random stalls, field-by-field compare
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        rfc_pkg::out_payload_t got;
        rfc_pkg::out_payload_t want;
        int                    stall;
        if (!rst_n)
        begin
            tx_ch.ready <= 1'b0;
            sink_stall  <= 0;
        end
        else
        begin
            stall = (sink_stall != 0) ? sink_stall - 1 : 0;
            if (tx_ch.valid && tx_ch.ready)
            begin
                got = tx_ch.data;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 32'(got.data_byte), 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.data_byte != want.data_byte)
                        report_mismatch("data_byte", 32'(got.data_byte),
                                        32'(want.data_byte));
                    if (got.payload_flag != want.payload_flag)
                        report_mismatch("payload_flag", 32'(got.payload_flag),
                                        32'(want.payload_flag));
                    if (got.frame_done != want.frame_done)
                        report_mismatch("frame_done", 32'(got.frame_done),
                                        32'(want.frame_done));
                    if (got.error_code != want.error_code)
                        report_mismatch("error_code", 32'(got.error_code),
                                        32'(want.error_code));
                    if (got.frame_type != want.frame_type)
                        report_mismatch("frame_type", 32'(got.frame_type),
                                        32'(want.frame_type));
                    if (got.payload_length != want.payload_length)
                        report_mismatch("payload_length", 32'(got.payload_length),
                                        32'(want.payload_length));
                    if (want.frame_done)
                        verdict_hits[want.error_code] = 1'b1;
                    if (want.payload_flag)
                        flagged_bytes++;
                end
                results_checked++;
                stall = draw_gap(sink_quiet);
            end
            sink_stall  <= stall;
            tx_ch.ready <= (stall == 0) && !sink_hold;
        end
    end

    // long receiver hold-off so the checker backs up into rx
    initial
    begin : receiver_hold_off
        sink_hold <= 1'b0;
        wait (hold_req);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // stimulus: directed frames per setting, then random phases
    initial
    begin : stimulus
        int          random_bytes;
        int          phase_start;
        int          phase_no;
        int          pay_len;
        int          codes_hit;
        frame_flaw_t flaw;
        logic [7:0]  etype;
        logic [7:0]  rhdr;
        bit          quiet_src;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        model_cfg.expected_type   = 8'h00;
        model_cfg.response_header = rfc_pkg::RESPONSE_HEADER_RST;
        model_cfg.status_mode     = 1'b0;
        clear_frame_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: short frames, good frames, header, length, footer, checksum and truncation damage
        push_byte(rfc_pkg::HEADER_FIRST, 1'b1);
        queue_frame(0, FL_NONE, -1, 8);
        queue_frame(0, FL_NONE, -1, 0);
        queue_frame(3, FL_NONE, 8'h00, 0);
        queue_frame(3, FL_NONE, 8'hFF, 0);
        queue_frame(2, FL_HEADER0, -1, 0);
        queue_frame(2, FL_HEADER1, -1, 0);
        queue_frame(2, FL_LENGTH, -1, 0);
        queue_frame(2, FL_FOOTER, -1, 0);
        queue_frame(2, FL_CHECKSUM, -1, 0);
        queue_frame(5, FL_TRUNCATED, -1, 0);
        wait_drained();

        // strict type, header byte zero, plus a write to the spare index
        apply_settings(8'hFF, 8'h00, 1'b0);
        write_reg(CFG_SPARE, 8'hA5);
        queue_frame(1, FL_NONE, -1, 0);
        queue_frame(1, FL_TYPE, -1, 0);
        queue_frame(1, FL_HEADER1, -1, 0);
        wait_drained();

        // status replies
        apply_settings(8'h01, 8'hFF, 1'b1);
        queue_frame(1, FL_NONE, 32'(rfc_pkg::STATUS_OK), 0);
        queue_frame(1, FL_NONE, 32'(rfc_pkg::STATUS_INVALID), 0);
        queue_frame(1, FL_NONE, 32'(rfc_pkg::STATUS_UNSUPP), 0);
        queue_frame(1, FL_NONE, 8'h42, 0);
        queue_frame(0, FL_NONE, -1, 0);
        queue_frame(2, FL_NONE, 32'(rfc_pkg::STATUS_OK), 0);
        queue_frame(1, FL_CHECKSUM, 32'(rfc_pkg::STATUS_INVALID), 0);
        wait_drained();

        // random phases, each with fresh settings
        random_bytes = 0;
        phase_no     = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            case ($urandom_range(0, 5))
                0, 1:    etype = 8'h00;
                2:       etype = 8'hFF;
                default: etype = 8'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       rhdr = 8'h00;
                1:       rhdr = 8'hFF;
                2, 3:    rhdr = rfc_pkg::RESPONSE_HEADER_RST;
                default: rhdr = 8'($urandom);
            endcase
            apply_settings(etype, rhdr, 1'($urandom_range(0, 1)));
            quiet_src = (phase_no == 1) || ($urandom_range(0, 3) == 0);
            src_quiet  <= quiet_src;
            sink_quiet <= ($urandom_range(0, 3) == 0);
            if (phase_no == 1)
                hold_req <= 1'b1;
            phase_start = bytes_pushed;
            while (bytes_pushed - phase_start < PHASE_BYTES)
            begin
                if (model_cfg.status_mode)
                    pay_len = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 3);
                else if ($urandom_range(0, 15) == 0)
                    pay_len = $urandom_range(13, 48);
                else
                    pay_len = $urandom_range(0, 12);
                flaw = ($urandom_range(0, 9) < 6) ? FL_NONE
                                                  : frame_flaw_t'($urandom_range(1, FL_NOISE));
                queue_frame(pay_len, flaw, -1, 0);
            end
            random_bytes = random_bytes + (bytes_pushed - phase_start);
            wait_drained();
            phase_no++;
        end

        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), 0);
        codes_hit = 0;
        for (int i = 0; i < VERDICT_COUNT; i++)
            codes_hit += verdict_hits[i];
        $display("run: %0d frames, %0d bytes, %0d register settings, %0d-cycle hold-off",
                 frames_queued, bytes_pushed, settings_used, HOLD_CYCLES);
        $display("verdict codes reached %0d of %0d, payload bytes flagged %0d, mismatches %0d",
                 codes_hit, VERDICT_COUNT, flagged_bytes, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
